/* rtl/ght_pkg.sv */
// Package: sizes, codes, entry layout and sequencer states of the handle table.
package ght_pkg;

   localparam int GROUP_SIZE  = 64;
   localparam int GROUP_COUNT = 16;
   localparam int REV_BITS    = 8;
   localparam int SLOTS       = GROUP_SIZE * GROUP_COUNT;
   localparam int IDX_BITS    = 10;
   localparam int OFS_BITS    = $clog2(GROUP_SIZE);
   localparam int GRP_BITS    = (GROUP_COUNT > 1) ? $clog2(GROUP_COUNT) : 1;
   localparam int TOK_BITS    = IDX_BITS + 8;
   localparam int POS_BITS    = IDX_BITS + 1;

   localparam logic [TOK_BITS-1:0] NULL_TOKEN = '1;

   typedef enum logic [2:0] {
      KIND_NEW    = 3'd0,
      KIND_LOOKUP = 3'd1,
      KIND_SETTYP = 3'd2,
      KIND_REMOVE = 3'd3,
      KIND_FIND   = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      STAT_OK   = 2'd0,
      STAT_MISS = 2'd1,
      STAT_FULL = 2'd2
   } status_type;

   typedef struct packed {
      logic [7:0]  rev;
      logic [31:0] payload;
      logic [15:0] kind;
      logic [15:0] owner;
   } entry_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_NEW_RD,
      ST_NEW_CHK,
      ST_NEW_REV,
      ST_NEW_WR,
      ST_TOK_RD,
      ST_TOK_CHK,
      ST_FIND_RD,
      ST_FIND_CHK,
      ST_DONE
   } state_type;

endpackage

/* rtl/generation_handle_table.sv */
// Top level: generational handle table with a small sequencer over two memories.
//
// Channels: req_ carries one operation per item (tuser = kind: new, lookup,
// set type, remove, find next); rsp_ returns exactly one result item per
// request (tuser = status). No configuration port.
// Steps per operation (a new request is accepted only in idle, after the
// previous result has gone to the output register):
//   lookup / set type / remove : read live word and entry, check, finish
//   new                        : check group words in turn, read revision, write
//   find next                  : check slots in turn from start_pos
//   find next past table, kinds 5..7 : finish at once
// Each memory has a single registered read port: one group word or one slot
// is read and then checked at a time.
// Reset: a clearing pass writes every entry (revision 0) and every live
// word; req_tready stays low until it ends.
// Stalls: the result sits in an output register; a new request is taken while
// it waits, but a finished item holds in its final state until that one is taken.
module generation_handle_table (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // token[17:0], owner[33:18], entry_type[49:34], data_in[81:50],
   // any_owner[82], start_pos[93:83], zero fill [95:94]
   input  logic [95:0] req_tdata,
   // kind[2:0]
   input  logic [2:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // token_out[17:0], type_out[33:18], data_out[65:34], next_pos[76:66],
   // zero fill [79:77]
   output logic [79:0] rsp_tdata,
   // status[1:0]
   output logic [1:0]  rsp_tuser
);
   import ght_pkg::*;

   // memories
   logic [GROUP_SIZE-1:0] live_mem [GROUP_COUNT];
   entry_type             entry_mem [SLOTS];

   logic [GROUP_SIZE-1:0] live_rd_ff;
   entry_type             entry_rd_ff;

   logic [GRP_BITS-1:0]   live_raddr, live_waddr;
   logic                  live_we;
   logic [GROUP_SIZE-1:0] live_wdata;
   logic [IDX_BITS-1:0]   entry_raddr, entry_waddr;
   logic                  entry_we;
   entry_type             entry_wdata;

   // sequencer
   state_type state_ff, state_in;

   // latched request
   logic [2:0]          kind_ff, kind_in;
   logic [TOK_BITS-1:0] tok_ff, tok_in;
   logic [15:0]         own_ff, own_in;
   logic [15:0]         typ_ff, typ_in;
   logic [31:0]         dat_ff, dat_in;
   logic                any_ff, any_in;

   // working registers
   logic [IDX_BITS-1:0]   cnt_ff, cnt_in;      // clear index / find position
   logic [GRP_BITS-1:0]   grp_ff, grp_in;      // group scan index
   logic                  fe_ok_ff, fe_ok_in;  // an empty group seen
   logic [GRP_BITS-1:0]   fe_ff, fe_in;        // lowest empty group
   logic [IDX_BITS-1:0]   idx_ff, idx_in;      // chosen slot
   logic [GROUP_SIZE-1:0] word_ff, word_in;    // live word of chosen group

   // result being built
   logic [1:0]          r_stat_ff, r_stat_in;
   logic [TOK_BITS-1:0] r_tok_ff, r_tok_in;
   logic [15:0]         r_typ_ff, r_typ_in;
   logic [31:0]         r_dat_ff, r_dat_in;
   logic [POS_BITS-1:0] r_pos_ff, r_pos_in;

   // output register
   logic        rsp_valid_ff, rsp_valid_in;
   logic [79:0] rsp_data_ff, rsp_data_in;
   logic [1:0]  rsp_user_ff, rsp_user_in;

   // lowest free slot in the scanned word
   logic [OFS_BITS-1:0] free_ofs;
   always_comb begin
      free_ofs = '0;
      for (int i = GROUP_SIZE - 1; i >= 0; i--) begin
         if (!live_rd_ff[i]) free_ofs = OFS_BITS'(i);
      end
   end

   logic                word_part, word_empty, last_grp;
   logic                tok_ok, find_hit;
   logic [7:0]          rev_bump;
   logic [IDX_BITS-1:0] tok_idx;
   logic                out_free;

   assign word_part  = (live_rd_ff != '0) && (live_rd_ff != '1);
   assign word_empty = (live_rd_ff == '0);
   assign last_grp   = (grp_ff == GRP_BITS'(GROUP_COUNT - 1));
   assign tok_idx    = tok_ff[IDX_BITS-1:0];
   assign tok_ok     = (tok_ff != NULL_TOKEN)
                       && live_rd_ff[tok_idx[OFS_BITS-1:0]]
                       && (entry_rd_ff.rev == tok_ff[TOK_BITS-1:IDX_BITS]);
   assign find_hit   = live_rd_ff[cnt_ff[OFS_BITS-1:0]]
                       && (entry_rd_ff.kind == typ_ff)
                       && (any_ff || (entry_rd_ff.owner == own_ff));
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      // revision bump; a token equal to null forces revision 0
      rev_bump = REV_BITS'(entry_rd_ff.rev + 8'd1);
      if ({rev_bump, idx_ff} == NULL_TOKEN) rev_bump = '0;
   end

   assign req_tready = (state_ff == ST_IDLE);

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      tok_in     = tok_ff;
      own_in     = own_ff;
      typ_in     = typ_ff;
      dat_in     = dat_ff;
      any_in     = any_ff;
      cnt_in     = cnt_ff;
      grp_in     = grp_ff;
      fe_ok_in   = fe_ok_ff;
      fe_in      = fe_ff;
      idx_in     = idx_ff;
      word_in    = word_ff;
      r_stat_in  = r_stat_ff;
      r_tok_in   = r_tok_ff;
      r_typ_in   = r_typ_ff;
      r_dat_in   = r_dat_ff;
      r_pos_in   = r_pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;

      live_raddr  = grp_ff;
      live_waddr  = grp_ff;
      live_we     = 1'b0;
      live_wdata  = word_ff;
      entry_raddr = idx_ff;
      entry_waddr = idx_ff;
      entry_we    = 1'b0;
      entry_wdata = entry_rd_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            entry_we    = 1'b1;
            entry_waddr = cnt_ff;
            entry_wdata = '0;
            live_we     = (cnt_ff < IDX_BITS'(GROUP_COUNT));
            live_waddr  = cnt_ff[GRP_BITS-1:0];
            live_wdata  = '0;
            cnt_in      = cnt_ff + 1'b1;
            if (cnt_ff == IDX_BITS'(SLOTS - 1)) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               kind_in  = req_tuser;
               tok_in   = req_tdata[17:0];
               own_in   = req_tdata[33:18];
               typ_in   = req_tdata[49:34];
               dat_in   = req_tdata[81:50];
               any_in   = req_tdata[82];
               r_stat_in = STAT_MISS;
               r_tok_in  = '0;
               r_typ_in  = '0;
               r_dat_in  = '0;
               r_pos_in  = '0;
               grp_in    = '0;
               fe_ok_in  = 1'b0;
               case (req_tuser)
                  KIND_NEW: state_in = ST_NEW_RD;
                  KIND_LOOKUP, KIND_SETTYP, KIND_REMOVE: state_in = ST_TOK_RD;
                  KIND_FIND: begin
                     r_pos_in = req_tdata[93:83];
                     cnt_in   = req_tdata[92:83];
                     if (req_tdata[93:83] >= POS_BITS'(SLOTS)) state_in = ST_DONE;
                     else state_in = ST_FIND_RD;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_NEW_RD: begin
            live_raddr = grp_ff;
            state_in   = ST_NEW_CHK;
         end
         ST_NEW_CHK: begin
            if (word_part) begin
               idx_in   = IDX_BITS'({grp_ff, free_ofs});
               word_in  = live_rd_ff;
               state_in = ST_NEW_REV;
            end else begin
               if (word_empty && !fe_ok_ff) begin
                  fe_ok_in = 1'b1;
                  fe_in    = grp_ff;
               end
               if (!last_grp) begin
                  grp_in   = grp_ff + 1'b1;
                  state_in = ST_NEW_RD;
               end else if (fe_ok_ff || word_empty) begin
                  grp_in   = fe_ok_ff ? fe_ff : grp_ff;
                  idx_in   = IDX_BITS'({(fe_ok_ff ? fe_ff : grp_ff), OFS_BITS'(0)});
                  word_in  = '0;
                  state_in = ST_NEW_REV;
               end else begin
                  r_stat_in = STAT_FULL;
                  state_in  = ST_DONE;
               end
            end
         end
         ST_NEW_REV: begin
            entry_raddr = idx_ff;
            state_in    = ST_NEW_WR;
         end
         ST_NEW_WR: begin
            entry_we            = 1'b1;
            entry_waddr         = idx_ff;
            entry_wdata.rev     = rev_bump;
            entry_wdata.payload = dat_ff;
            entry_wdata.kind    = typ_ff;
            entry_wdata.owner   = own_ff;
            live_we             = 1'b1;
            live_waddr          = grp_ff;
            live_wdata          = word_ff;
            live_wdata[idx_ff[OFS_BITS-1:0]] = 1'b1;
            r_stat_in = STAT_OK;
            r_tok_in  = {rev_bump, idx_ff};
            state_in  = ST_DONE;
         end
         ST_TOK_RD: begin
            live_raddr  = tok_idx[IDX_BITS-1:OFS_BITS];
            entry_raddr = tok_idx;
            state_in    = ST_TOK_CHK;
         end
         ST_TOK_CHK: begin
            if (tok_ok) begin
               r_stat_in = STAT_OK;
               case (kind_ff)
                  KIND_LOOKUP: begin
                     r_typ_in = entry_rd_ff.kind;
                     r_dat_in = entry_rd_ff.payload;
                  end
                  KIND_SETTYP: begin
                     entry_we         = 1'b1;
                     entry_waddr      = tok_idx;
                     entry_wdata.kind = typ_ff;
                  end
                  default: begin
                     live_we    = 1'b1;
                     live_waddr = tok_idx[IDX_BITS-1:OFS_BITS];
                     live_wdata = live_rd_ff;
                     live_wdata[tok_idx[OFS_BITS-1:0]] = 1'b0;
                  end
               endcase
            end
            state_in = ST_DONE;
         end
         ST_FIND_RD: begin
            live_raddr  = cnt_ff[IDX_BITS-1:OFS_BITS];
            entry_raddr = cnt_ff;
            state_in    = ST_FIND_CHK;
         end
         ST_FIND_CHK: begin
            if (find_hit) begin
               r_stat_in = STAT_OK;
               r_dat_in  = entry_rd_ff.payload;
               r_pos_in  = {1'b0, cnt_ff} + 1'b1;
               state_in  = ST_DONE;
            end else if (cnt_ff == IDX_BITS'(SLOTS - 1)) begin
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 1'b1;
               state_in = ST_FIND_RD;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {3'b000, r_pos_ff, r_dat_ff, r_typ_ff, r_tok_ff};
               rsp_user_in  = r_stat_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // memories: one write and one registered read port each
   always_ff @(posedge clock) begin
      if (live_we) live_mem[live_waddr] <= live_wdata;
      live_rd_ff <= live_mem[live_raddr];
      if (entry_we) entry_mem[entry_waddr] <= entry_wdata;
      entry_rd_ff <= entry_mem[entry_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff     <= kind_in;
      tok_ff      <= tok_in;
      own_ff      <= own_in;
      typ_ff      <= typ_in;
      dat_ff      <= dat_in;
      any_ff      <= any_in;
      grp_ff      <= grp_in;
      fe_ok_ff    <= fe_ok_in;
      fe_ff       <= fe_in;
      idx_ff      <= idx_in;
      word_ff     <= word_in;
      r_stat_ff   <= r_stat_in;
      r_tok_ff    <= r_tok_in;
      r_typ_ff    <= r_typ_in;
      r_dat_ff    <= r_dat_in;
      r_pos_ff    <= r_pos_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_ready_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> (state_ff == ST_IDLE))
      else $error("ready outside idle");

   a_new_writes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_NEW_WR) |-> (entry_we && live_we))
      else $error("allocation without write");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == ST_DONE))
      else $error("result not from finish state");

   a_clear_quiet: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR) |-> !rsp_tvalid)
      else $error("result during clearing pass");

endmodule
